### hdl/pfd_pkg.sv
package pfd_pkg;

   // operation codes carried in func
   localparam logic [1:0] FUNC_FILL   = 2'd0;
   localparam logic [1:0] FUNC_PIXEL  = 2'd1;
   localparam logic [1:0] FUNC_BITMAP = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   // linear address arithmetic: 5-bit page times 8-bit width plus 8-bit column
   localparam int LIN_ADDR_W = 13;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic       on;
      logic [7:0] value;
      logic [7:0] bmp_width;
      logic [7:0] bmp_height;
      logic [7:0] row_index;
      logic [4:0] byte_column;
      logic [2:0] page_sel;
   } pfd_req_type;

   typedef struct packed {
      logic [7:0] read_data;
   } pfd_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_CALC,
      ST_READ,
      ST_WRITE,
      ST_DONE
   } pfd_state_type;

endpackage

### hdl/pfd_chan_if.sv
interface pfd_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hdl/page_framebuffer_draw.sv
// A pixel or read word passes ST_CALC, then on a hit ST_READ and, for a pixel, ST_WRITE, and ends in ST_DONE;
// a bitmap byte runs ST_CALC once per pixel, with ST_READ and ST_WRITE for each drawn one, and a fill
// writes every RAM word in turn in ST_FILL before ST_DONE.
// Throughput: one item at a time; ready is back in the cycle the result is loaded, and a
// result still held in the output register stalls the next one in ST_DONE.
// Reset: a clearing pass zeroes every RAM word; no word is accepted until it ends.
module page_framebuffer_draw import pfd_pkg::*; #(
   parameter int PANEL_WIDTH = 128,
   parameter int PAGE_COUNT  = 8
) (
   input logic        clock,
   input logic        reset,
   pfd_chan_if.sink   req_if,
   pfd_chan_if.source rsp_if
);

   localparam int DEPTH      = PAGE_COUNT * PANEL_WIDTH;
   localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PANEL_ROWS = PAGE_COUNT * 8;

   pfd_state_type state_ff, state_in;
   pfd_req_type   item_ff, item_in;
   logic [2:0]    bit_ff, bit_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [7:0]    mask_ff, mask_in;
   logic          set_ff, set_in;
   logic          hit_ff, hit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata, ram_rdata;

   // pixel address unit
   logic [7:0]            px_col, px_row, px_p;
   logic [4:0]            px_page;
   logic                  px_set, px_en, px_hit;
   logic [LIN_ADDR_W-1:0] px_lin;

   always_comb begin
      px_p    = {item_ff.byte_column, bit_ff};
      px_col  = item_ff.x_pos;
      px_row  = item_ff.y_pos;
      px_set  = item_ff.on;
      px_en   = 1'b1;
      px_page = px_row[7:3];
      px_hit  = 1'b0;
      unique case (item_ff.func)
         FUNC_BITMAP: begin
            px_col = item_ff.x_pos + px_p;
            px_row = item_ff.y_pos + item_ff.row_index;
            px_set = item_ff.value[bit_ff];
            px_en  = (px_p < item_ff.bmp_width) && (item_ff.row_index < item_ff.bmp_height);
            px_page = px_row[7:3];
         end
         FUNC_READ: begin
            px_page = {2'b00, item_ff.page_sel};
         end
         default: begin
            px_page = px_row[7:3];
         end
      endcase
      if (item_ff.func == FUNC_READ) begin
         px_hit = (px_page < 5'(PAGE_COUNT)) && (px_col < 8'(PANEL_WIDTH));
      end else begin
         px_hit = px_en && (px_col < 8'(PANEL_WIDTH)) && ({1'b0, px_row} < 9'(PANEL_ROWS));
      end
      px_lin = LIN_ADDR_W'(px_page) * LIN_ADDR_W'(PANEL_WIDTH) + LIN_ADDR_W'(px_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      addr_ff     <= addr_in;
      mask_ff     <= mask_in;
      set_ff      <= set_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      logic last_pixel;

      state_in     = state_ff;
      item_in      = item_ff;
      bit_in       = bit_ff;
      sweep_in     = sweep_ff;
      addr_in      = addr_ff;
      mask_in      = mask_ff;
      set_in       = set_ff;
      hit_in       = hit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      req_if.ready = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = sweep_ff;
      ram_wdata    = '0;
      last_pixel   = (item_ff.func != FUNC_BITMAP) || (bit_ff == 3'd7);

      unique case (state_ff)
         ST_CLEAR, ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = (state_ff == ST_FILL) ? item_ff.value : 8'd0;
            if (sweep_ff == AW'(DEPTH - 1)) begin
               sweep_in = '0;
               state_in = (state_ff == ST_FILL) ? ST_DONE : ST_IDLE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               item_in  = req_if.data;
               bit_in   = '0;
               state_in = (req_if.data.func == FUNC_FILL) ? ST_FILL : ST_CALC;
            end
         end
         ST_CALC: begin
            addr_in = px_lin[AW-1:0];
            mask_in = 8'(1) << px_row[2:0];
            set_in  = px_set;
            hit_in  = px_hit;
            if (px_hit) begin
               state_in = ST_READ;
            end else if (last_pixel) begin
               state_in = ST_DONE;
            end else begin
               bit_in = bit_ff + 3'd1;
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = (item_ff.func == FUNC_READ) ? ST_DONE : ST_WRITE;
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = set_ff ? (ram_rdata | mask_ff) : (ram_rdata & ~mask_ff);
            if (last_pixel) begin
               state_in = ST_DONE;
            end else begin
               bit_in   = bit_ff + 3'd1;
               state_in = ST_CALC;
            end
         end
         ST_DONE: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (item_ff.func == FUNC_READ && hit_ff) ? ram_rdata : 8'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   pfd_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.data.read_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_write_mask_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> $onehot(mask_ff))
      else $error("pixel write mask not one-hot");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> hit_ff && ({1'b0, addr_ff} < (AW + 1)'(DEPTH)))
      else $error("pixel write outside panel");

   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && item_ff.func != FUNC_READ |-> rsp_data_ff == 8'd0)
      else $error("non-read word returned nonzero data");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> state_ff == ST_FILL || state_ff == ST_CALC)
      else $error("accepted word did not start work");
`endif

endmodule

### hdl/pfd_ram.sv
module pfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
